>>> hw/rtl/rtt_pkg.sv
// shared types and codes for the retrying timeout table
`default_nettype none
package rtt_pkg;

	localparam int KEY_W   = 32;
	localparam int TIME_W  = 32;
	localparam int TRIES_W = 8;
	localparam int FUNC_W  = 2;
	localparam int KIND_W  = 3;

	localparam logic [FUNC_W-1:0] FN_ARM     = 2'd0;
	localparam logic [FUNC_W-1:0] FN_CANCEL  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_ADVANCE = 2'd2;
	localparam logic [FUNC_W-1:0] FN_NONE    = 2'd3;

	localparam logic [KIND_W-1:0] KD_ARMED     = 3'd0;
	localparam logic [KIND_W-1:0] KD_FULL      = 3'd1;
	localparam logic [KIND_W-1:0] KD_CANCELLED = 3'd2;
	localparam logic [KIND_W-1:0] KD_NOT_FOUND = 3'd3;
	localparam logic [KIND_W-1:0] KD_RETRY     = 3'd4;
	localparam logic [KIND_W-1:0] KD_EXPIRED   = 3'd5;
	localparam logic [KIND_W-1:0] KD_NEXT      = 3'd6;

	localparam logic REG_CEILING = 1'b0;
	localparam logic [TIME_W-1:0] CEILING_RESET = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [TIME_W-1:0]  remaining;
		logic [TIME_W-1:0]  reload;
		logic [TRIES_W-1:0] tries;
		logic               retry_on;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic go;
		logic close_emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              ev;
		logic              term;
		logic              out_free;
	} dp_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/retrying_timeout_table_unit.sv
// top level of the retrying timeout table
// A table of ENTRIES keyed one-shot timers with retries. Each input transfer arms,
// cancels or advances; a transfer with func none gives no result. Each operation
// walks the slot table through the read port of the table ram, one slot behind the
// read address, at one slot per cycle while no slot event waits for the downstream
// side to take the result register. An advance walks every slot and ends with the
// closing next-timeout result (accept, slot reads, slot updates one behind the
// reads, closing result); an arm or cancel ends at the first matching slot, or with
// a closing table full or not found result after the last slot.
// Write the configuration only while no operation is in flight.
`default_nettype none
module retrying_timeout_table_unit #(
	parameter int ENTRIES = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// slave side
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [111:0] s_tdata, // key, timeout, tries, retry_enabled, elapsed, zero pad
	input  wire logic [1:0]   s_tuser, // func
	// master side
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [71:0]  m_tdata, // key_res, next_timeout, has_next, zero pad
	output logic      [2:0]   m_tuser, // kind
	output logic              m_tlast,
	// apb configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	rtt_pkg::ctrl_cmd_t         cmd;
	rtt_pkg::dp_status_t        sts;
	logic [IDX_W-1:0]           rd_idx;
	logic [IDX_W-1:0]           proc_idx;
	logic [rtt_pkg::TIME_W-1:0] ceiling;

	rtt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ceiling (ceiling)
	);

	rtt_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.proc_idx (proc_idx)
	);

	rtt_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.rd_idx   (rd_idx),
		.proc_idx (proc_idx),
		.ceiling  (ceiling),
		.in_data  (s_tdata),
		.in_user  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

>>> hw/rtl/rtt_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module rtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/rtt_regs.sv
// configuration register block on the apb port
`default_nettype none
module rtt_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [rtt_pkg::TIME_W-1:0] ceiling
);
	logic [rtt_pkg::TIME_W-1:0] ceiling_q;
	logic                       wr_ceiling;

	assign pready     = 1'b1;
	assign wr_ceiling = psel && penable && pwrite && (paddr[2] == rtt_pkg::REG_CEILING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= rtt_pkg::CEILING_RESET;
		end else if (wr_ceiling) begin
			ceiling_q <= pwdata;
		end
	end

	always_comb begin
		unique case (paddr[2])
			rtt_pkg::REG_CEILING: prdata = ceiling_q;
			default:              prdata = 32'd0;
		endcase
	end

	assign ceiling = ceiling_q;

endmodule
`default_nettype wire

>>> hw/rtl/rtt_ctrl.sv
// sequencer: slot scan counter, read stage and op state machine
`default_nettype none
module rtt_ctrl #(
	parameter int ENTRIES = 16,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire rtt_pkg::dp_status_t sts,
	output rtt_pkg::ctrl_cmd_t       cmd,
	output logic [IDX_W-1:0]         rd_idx,
	output logic [IDX_W-1:0]         proc_idx
);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_CLOSE = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             stage_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             scan_on, stall, go, rd_en, cnt_done, is_last, load;

	assign in_ready = (state_q == ST_IDLE);
	assign load     = in_valid && in_ready;
	assign cnt_done = (rd_cnt_q == CNT_W'(ENTRIES));
	assign is_last  = (idx_s1 == IDX_W'(ENTRIES - 1));
	assign scan_on  = (state_q == ST_SCAN) && (sts.func != rtt_pkg::FN_NONE);
	assign stall    = scan_on && stage_vld_s1 && sts.ev && !sts.out_free;
	assign go       = scan_on && stage_vld_s1 && !stall;
	assign rd_en    = scan_on && !cnt_done && !stall;

	assign cmd.load       = load;
	assign cmd.rd_en      = rd_en;
	assign cmd.go         = go;
	assign cmd.close_emit = (state_q == ST_CLOSE) && sts.out_free;

	assign rd_idx   = rd_cnt_q[IDX_W-1:0];
	assign proc_idx = idx_s1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (load) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.func == rtt_pkg::FN_NONE) begin
					state_d = ST_IDLE;
				end else if (go && sts.term) begin
					state_d = ST_IDLE;
				end else if (go && is_last) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_cnt_q     <= '0;
			stage_vld_s1 <= 1'b0;
			idx_s1       <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				rd_cnt_q     <= '0;
				stage_vld_s1 <= 1'b0;
			end else begin
				if (rd_en) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
				if (!stall) begin
					stage_vld_s1 <= rd_en;
					idx_s1       <= rd_idx;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/rtt_datapath.sv
// item registers, slot table, per-slot update, shortest search and output register
`default_nettype none
module rtt_datapath #(
	parameter int ENTRIES = 16,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rtt_pkg::ctrl_cmd_t  cmd,
	output rtt_pkg::dp_status_t      sts,
	input  wire logic [IDX_W-1:0]    rd_idx,
	input  wire logic [IDX_W-1:0]    proc_idx,
	input  wire logic [rtt_pkg::TIME_W-1:0] ceiling,
	input  wire logic [111:0]        in_data,
	input  wire logic [1:0]          in_user,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [71:0]              m_tdata,
	output logic [2:0]               m_tuser,
	output logic                     m_tlast
);
	logic [rtt_pkg::FUNC_W-1:0]  func_q;
	logic [rtt_pkg::KEY_W-1:0]   key_q;
	logic [rtt_pkg::TIME_W-1:0]  timeout_q;
	logic [rtt_pkg::TRIES_W-1:0] tries_q;
	logic                        retry_q;
	logic [rtt_pkg::TIME_W-1:0]  elapsed_q;

	logic [ENTRIES-1:0]          valid_q;
	logic [rtt_pkg::TIME_W-1:0]  best_q;
	logic                        found_q;

	logic                        out_vld_q;
	logic [rtt_pkg::KIND_W-1:0]  out_kind_q;
	logic [rtt_pkg::KEY_W-1:0]   out_key_q;
	logic [rtt_pkg::TIME_W-1:0]  out_nt_q;
	logic                        out_has_q;
	logic                        out_last_q;

	rtt_pkg::entry_t             rdata, wdata;
	logic                        we;
	logic                        slot_vld, key_hit, fits, can_retry;
	logic                        ev, term, set_vld, clr_vld, still_vld;
	logic [rtt_pkg::KIND_W-1:0]  ev_kind;
	logic [rtt_pkg::TIME_W-1:0]  new_rem, lim;
	logic                        qualify, out_free;

	rtt_ram #(
		.WIDTH ($bits(rtt_pkg::entry_t)),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (proc_idx),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (rd_idx),
		.rdata (rdata)
	);

	assign slot_vld  = valid_q[proc_idx];
	assign key_hit   = (rdata.key == key_q);
	assign fits      = (elapsed_q < rdata.remaining);
	assign can_retry = (rdata.tries != '0) && rdata.retry_on;
	assign out_free  = !out_vld_q || m_tready;
	assign lim       = found_q ? best_q : ceiling;

	always_comb begin
		ev        = 1'b0;
		term      = 1'b0;
		ev_kind   = rtt_pkg::KD_ARMED;
		we        = 1'b0;
		wdata     = rdata;
		set_vld   = 1'b0;
		clr_vld   = 1'b0;
		still_vld = 1'b0;
		new_rem   = rdata.remaining;
		case (func_q)
			rtt_pkg::FN_ARM: begin
				ev      = !slot_vld;
				term    = !slot_vld;
				ev_kind = rtt_pkg::KD_ARMED;
				we      = !slot_vld;
				set_vld = !slot_vld;
				wdata.key       = key_q;
				wdata.remaining = timeout_q;
				wdata.reload    = timeout_q;
				wdata.tries     = tries_q;
				wdata.retry_on  = retry_q;
			end
			rtt_pkg::FN_CANCEL: begin
				ev      = slot_vld && key_hit;
				term    = slot_vld && key_hit;
				ev_kind = rtt_pkg::KD_CANCELLED;
				clr_vld = slot_vld && key_hit;
			end
			rtt_pkg::FN_ADVANCE: begin
				if (slot_vld) begin
					if (fits) begin
						new_rem   = rdata.remaining - elapsed_q;
						we        = 1'b1;
						still_vld = 1'b1;
					end else if (can_retry) begin
						new_rem     = rdata.reload;
						wdata.tries = rdata.tries - rtt_pkg::TRIES_W'(1);
						we          = 1'b1;
						still_vld   = 1'b1;
						ev          = 1'b1;
						ev_kind     = rtt_pkg::KD_RETRY;
					end else begin
						clr_vld = 1'b1;
						ev      = 1'b1;
						ev_kind = rtt_pkg::KD_EXPIRED;
					end
				end
				wdata.remaining = new_rem;
			end
			default: begin
				ev = 1'b0;
			end
		endcase
		we = we && cmd.go;
	end

	assign qualify = still_vld && (new_rem != '0) && (new_rem < lim);

	assign sts.func     = func_q;
	assign sts.ev       = ev;
	assign sts.term     = term;
	assign sts.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= in_user;
			key_q     <= in_data[31:0];
			timeout_q <= in_data[63:32];
			tries_q   <= in_data[71:64];
			retry_q   <= in_data[72];
			elapsed_q <= in_data[104:73];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
		end else begin
			if (cmd.go && set_vld) begin
				valid_q[proc_idx] <= 1'b1;
			end
			if (cmd.go && clr_vld) begin
				valid_q[proc_idx] <= 1'b0;
			end
			if (cmd.load) begin
				found_q <= 1'b0;
				best_q  <= '0;
			end else if (cmd.go && qualify) begin
				found_q <= 1'b1;
				best_q  <= new_rem;
			end
		end
	end

	// result register: slot events or the closing result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.go && ev) begin
			out_vld_q <= 1'b1;
		end else if (cmd.close_emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go && ev) begin
			out_kind_q <= ev_kind;
			out_key_q  <= (func_q == rtt_pkg::FN_ADVANCE) ? rdata.key : key_q;
			out_nt_q   <= '0;
			out_has_q  <= 1'b0;
			out_last_q <= term;
		end else if (cmd.close_emit) begin
			out_last_q <= 1'b1;
			case (func_q)
				rtt_pkg::FN_ARM: begin
					out_kind_q <= rtt_pkg::KD_FULL;
					out_key_q  <= key_q;
					out_nt_q   <= '0;
					out_has_q  <= 1'b0;
				end
				rtt_pkg::FN_CANCEL: begin
					out_kind_q <= rtt_pkg::KD_NOT_FOUND;
					out_key_q  <= key_q;
					out_nt_q   <= '0;
					out_has_q  <= 1'b0;
				end
				default: begin
					out_kind_q <= rtt_pkg::KD_NEXT;
					out_key_q  <= '0;
					out_nt_q   <= found_q ? best_q : '0;
					out_has_q  <= found_q;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'd0, out_has_q, out_nt_q, out_key_q};

endmodule
`default_nettype wire
